>>> hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sine/cosine unit
// Fixed-point formats, reduction constants and the structs that the front
// end, the queue and the Taylor term pipeline exchange.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Default number of Taylor terms after the leading one.
  localparam int unsigned TERMS_DEFAULT = 10;

  // Field widths.
  localparam int unsigned ANGLE_W = 32;   // Q8.24 input angle
  localparam int unsigned VALUE_W = 32;   // Q2.30 result
  localparam int unsigned M_W     = 32;   // magnitude of the shifted angle
  localparam int unsigned R_W     = 26;   // reduced angle, below pi
  localparam int unsigned RR_W    = 2 * R_W;
  localparam int unsigned X2_W    = 32;   // r squared, Q4.28
  localparam int unsigned TERM_W  = 32;   // term magnitude, Q28
  localparam int unsigned ACC_W   = 36;   // signed partial sum, Q28
  localparam int unsigned SUM_W   = 33;   // rounded product ahead of the divide
  localparam int unsigned RECIP_W = 31;   // reciprocal of a term divisor
  localparam int unsigned QUOT_W  = 6;    // quotient of the reduction by pi
  localparam int unsigned TERM_FRAC = 28;
  localparam int unsigned X2_SHIFT  = 20;

  // Reduction by pi: quotient estimate is (m * RECIP_PI) >> RECIP_PI_SHIFT,
  // low by at most one.
  localparam logic [R_W-1:0]          PI_Q24         = 26'd52707179;
  localparam logic signed [ANGLE_W:0] HALFPI_Q24     = 33'sd26353589;
  localparam logic [12:0]             RECIP_PI       = 13'd5215;
  localparam int unsigned             RECIP_PI_SHIFT = 38;

  localparam logic [TERM_W-1:0]         ONE_TERM = 32'd268435456;
  localparam logic signed [ACC_W-1:0]   ONE_ACC  = 36'sd268435456;
  localparam logic signed [VALUE_W-1:0] ONE_Q30  = 32'sd1073741824;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Beat that crosses the queue from the front end to the term pipeline.
  typedef struct packed {
    logic            flip;
    logic [X2_W-1:0] x2;
  } item_t;

  // Stage-to-stage bundle of the term pipeline.
  typedef struct packed {
    logic                    valid;
    logic                    flip;
    logic [X2_W-1:0]         x2;
    logic [TERM_W-1:0]       term;
    logic signed [ACC_W-1:0] acc;
  } term_bus_t;

endpackage

>>> hdl/sct_if.sv
// ----------------------------------------------------------------------------
// sct_if: handshake channels of the sine/cosine unit
// Request, internal queue and result channels, each with valid, ready and
// its payload.
// ----------------------------------------------------------------------------
interface sct_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [sct_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, output operation, output angle, input ready);
  modport sink   (input valid, input operation, input angle, output ready);
endinterface

interface sct_q_if;
  logic            valid;
  logic            ready;
  sct_pkg::item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface sct_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sct_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> hdl/sine_cosine_taylor.sv
// ----------------------------------------------------------------------------
// sine_cosine_taylor: pipelined sine/cosine by Taylor series
// Range reduction by pi in a front end, a short queue, and a Taylor term
// pipeline with saturated Q2.30 output.
// ----------------------------------------------------------------------------
// Each request beat carries an operation (0 = cosine, 1 = sine) and a signed
// Q8.24 angle in radians; each produces exactly one result beat, a signed
// Q2.30 value clamped to plus or minus one, in request order. A sine request
// is evaluated as the cosine of pi/2 minus the angle, formed without wrap.
// The block accepts one beat per cycle while the queue has room and delivers
// one per cycle whenever the result side takes them. The path runs through
// seven front-end stages (reduction multiply, quotient correction, squaring),
// the queue, six stages per Taylor term (one 32x32 multiply, rounding,
// reciprocal divide, correction, accumulate) and the output register. A
// stalled result holds the term pipeline, while the four-beat queue keeps the
// front end accepting until it fills.
// ----------------------------------------------------------------------------
module sine_cosine_taylor #(
  parameter int unsigned TERMS = sct_pkg::TERMS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sct_in_if.sink      req_i,
  sct_out_if.source   rsp_o
);

  // Front end to queue, queue to term pipeline.
  sct_q_if front_q ();
  sct_q_if back_q ();

  // Reduce the angle and square the remainder.
  sct_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .q_o    (front_q)
  );

  // Absorb result-side stalls so requests keep flowing.
  sct_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_q),
    .pop_o  (back_q)
  );

  // Sum the series, apply the sign, saturate and hold the result beat.
  sct_back #(
    .TERMS (TERMS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (back_q),
    .rsp_o  (rsp_o)
  );

endmodule

>>> hdl/sct_front.sv
// ----------------------------------------------------------------------------
// sct_front: range reduction front end
// Shifts a sine request to cosine, reduces the angle modulo pi and forms
// the squared remainder and the sign flip for the term pipeline.
// ----------------------------------------------------------------------------
module sct_front (
  input  logic      clk_i,
  input  logic      rst_ni,
  sct_in_if.sink    req_i,
  sct_q_if.source   q_o
);

  localparam int unsigned Stages = 7;
  localparam int unsigned QprodW = sct_pkg::M_W + 13;

  logic [Stages-1:0] vld_q;
  logic              en;

  logic                               op_q;
  logic signed [sct_pkg::ANGLE_W-1:0] angle_q;
  logic [sct_pkg::M_W-1:0]            m1_q, m2_q, m3_q;
  logic [sct_pkg::QUOT_W-1:0]         qe2_q, qe3_q;
  logic [sct_pkg::M_W-1:0]            qp3_q;
  logic [sct_pkg::R_W-1:0]            r4_q;
  logic                               flip4_q, flip5_q, flip6_q;
  logic [sct_pkg::RR_W-1:0]           rr5_q;
  logic [sct_pkg::X2_W-1:0]           x2_6_q;

  logic signed [sct_pkg::ANGLE_W:0] t;
  logic signed [sct_pkg::ANGLE_W:0] t_neg;
  logic [sct_pkg::M_W-1:0]          m_d;
  logic [QprodW-1:0]                qprod;
  logic [sct_pkg::QUOT_W-1:0]       qe_d;
  logic [sct_pkg::M_W-1:0]          qp_d;
  logic [sct_pkg::M_W-1:0]          r0;
  logic                             rwrap;
  logic [sct_pkg::R_W-1:0]          r_d;
  logic [sct_pkg::RR_W-1:0]         rr_d;
  logic [sct_pkg::RR_W-1:0]         rr_rnd;
  logic [sct_pkg::X2_W-1:0]         x2_d;

  // Advance whenever the last stage is empty or the queue takes its beat.
  assign en          = !vld_q[Stages-1] || q_o.ready;
  assign req_i.ready = en;

  assign q_o.valid     = vld_q[Stages-1];
  assign q_o.item.flip = flip6_q;
  assign q_o.item.x2   = x2_6_q;

  always_comb begin
    t      = op_q ? (sct_pkg::HALFPI_Q24 - 33'(angle_q)) : 33'(angle_q);
    t_neg  = -t;
    m_d    = t[sct_pkg::ANGLE_W] ? t_neg[sct_pkg::M_W-1:0] : t[sct_pkg::M_W-1:0];
    qprod  = QprodW'(m1_q) * QprodW'(sct_pkg::RECIP_PI);
    qe_d   = qprod[sct_pkg::RECIP_PI_SHIFT +: sct_pkg::QUOT_W];
    qp_d   = sct_pkg::M_W'(qe2_q) * sct_pkg::M_W'(sct_pkg::PI_Q24);
    r0     = m3_q - qp3_q;
    rwrap  = r0 >= sct_pkg::M_W'(sct_pkg::PI_Q24);
    r_d    = rwrap ? sct_pkg::R_W'(r0 - sct_pkg::M_W'(sct_pkg::PI_Q24))
                   : sct_pkg::R_W'(r0);
    rr_d   = sct_pkg::RR_W'(r4_q) * sct_pkg::RR_W'(r4_q);
    rr_rnd = rr5_q + (sct_pkg::RR_W'(1) << (sct_pkg::X2_SHIFT - 1));
    x2_d   = sct_pkg::X2_W'(rr_rnd >> sct_pkg::X2_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q    <= req_i.operation;
      angle_q <= req_i.angle;
      m1_q    <= m_d;
      m2_q    <= m1_q;
      qe2_q   <= qe_d;
      m3_q    <= m2_q;
      qe3_q   <= qe2_q;
      qp3_q   <= qp_d;
      r4_q    <= r_d;
      // Odd quotient flips the sign; a wrapped estimate was one short.
      flip4_q <= qe3_q[0] ^ rwrap;
      rr5_q   <= rr_d;
      flip5_q <= flip4_q;
      x2_6_q  <= x2_d;
      flip6_q <= flip5_q;
    end
  end

endmodule

>>> hdl/sct_fifo.sv
// ----------------------------------------------------------------------------
// sct_fifo: decoupling queue
// Short register queue between the front end and the term pipeline.
// ----------------------------------------------------------------------------
module sct_fifo (
  input  logic      clk_i,
  input  logic      rst_ni,
  sct_q_if.sink     push_i,
  sct_q_if.source   pop_o
);

  localparam int unsigned Depth = sct_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);

  sct_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign push_i.ready = cnt_q != (PtrW+1)'(Depth);
  assign pop_o.valid  = cnt_q != '0;
  assign pop_o.item   = mem_q[rd_q];
  assign push         = push_i.valid && push_i.ready;
  assign pop          = pop_o.valid && pop_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i.item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == (PtrW+1)'(Depth)) |-> wr_q == rd_q)
    else $error("queue pointers disagree with count");

  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o.valid && !pop_o.ready) |=> pop_o.item == $past(pop_o.item))
    else $error("queue head overwritten while stalled");
`endif

endmodule

>>> hdl/sct_term.sv
// ----------------------------------------------------------------------------
// sct_term: one Taylor term of the cosine series
// Scales the previous term by x squared over 2i(2i-1), rounded half up, and
// adds it to or subtracts it from the running sum. Six stages.
// ----------------------------------------------------------------------------
module sct_term #(
  parameter int unsigned IDX = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sct_pkg::term_bus_t bus_i,
  output sct_pkg::term_bus_t bus_o
);

  localparam int unsigned Stages = 6;
  localparam int unsigned SumW   = sct_pkg::SUM_W;
  localparam int unsigned ProdW  = SumW + sct_pkg::RECIP_W;
  // Half the series divisor; the other factor of two folds into the shift.
  localparam int unsigned Cdiv   = IDX * (2 * IDX - 1);
  localparam logic [sct_pkg::RECIP_W-1:0] Recip =
    sct_pkg::RECIP_W'((64'd1 << SumW) / Cdiv);
  localparam logic [SumW-1:0] CdivS = SumW'(Cdiv);
  localparam logic [63:0]     Round = 64'(Cdiv) << sct_pkg::TERM_FRAC;
  localparam logic            Sub   = IDX % 2 == 1;

  typedef struct packed {
    logic                             flip;
    logic [sct_pkg::X2_W-1:0]         x2;
    logic signed [sct_pkg::ACC_W-1:0] acc;
  } pass_t;

  logic [Stages-1:0]           vld_q;
  pass_t                       pass_q [Stages];
  logic [63:0]                 p_q;
  logic [SumW-1:0]             s2_q, s3_q, s4_q;
  logic [sct_pkg::TERM_W-1:0]  qe3_q, qe4_q, term5_q, term6_q;
  logic [SumW-1:0]             qc4_q;

  logic [63:0]                      p_rnd;
  logic [ProdW-1:0]                 qprod;
  logic [sct_pkg::TERM_W-1:0]       qe_d;
  logic [SumW-1:0]                  qc_d;
  logic [SumW-1:0]                  rem;
  logic [sct_pkg::TERM_W-1:0]       term_d;
  logic signed [sct_pkg::ACC_W-1:0] term_ext;
  logic signed [sct_pkg::ACC_W-1:0] acc_d;

  always_comb begin
    p_rnd    = p_q + Round;
    qprod    = ProdW'(s2_q) * ProdW'(Recip);
    // Unit divisor: the quotient is the rounded product itself.
    qe_d     = (Cdiv == 1) ? sct_pkg::TERM_W'(s2_q) : sct_pkg::TERM_W'(qprod >> SumW);
    qc_d     = SumW'(SumW'(qe3_q) * CdivS);
    rem      = s4_q - qc4_q;
    // Reciprocal estimate is at most one short.
    term_d   = (rem >= CdivS) ? qe4_q + 1'b1 : qe4_q;
    term_ext = sct_pkg::ACC_W'(term5_q);
    acc_d    = Sub ? pass_q[Stages-2].acc - term_ext : pass_q[Stages-2].acc + term_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], bus_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pass_q[0] <= '{flip: bus_i.flip, x2: bus_i.x2, acc: bus_i.acc};
      for (int k = 1; k < Stages - 1; k++) begin
        pass_q[k] <= pass_q[k-1];
      end
      pass_q[Stages-1] <= '{flip: pass_q[Stages-2].flip, x2: pass_q[Stages-2].x2,
                            acc: acc_d};
      p_q     <= 64'(bus_i.term) * 64'(bus_i.x2);
      s2_q    <= SumW'(p_rnd >> (sct_pkg::TERM_FRAC + 1));
      s3_q    <= s2_q;
      qe3_q   <= qe_d;
      s4_q    <= s3_q;
      qe4_q   <= qe3_q;
      qc4_q   <= qc_d;
      term5_q <= term_d;
      term6_q <= term5_q;
    end
  end

  assign bus_o.valid = vld_q[Stages-1];
  assign bus_o.flip  = pass_q[Stages-1].flip;
  assign bus_o.x2    = pass_q[Stages-1].x2;
  assign bus_o.acc   = pass_q[Stages-1].acc;
  assign bus_o.term  = term6_q;

endmodule

>>> hdl/sct_back.sv
// ----------------------------------------------------------------------------
// sct_back: Taylor series back end
// Chains the term stages, then scales, signs and saturates the sum into
// the output register.
// ----------------------------------------------------------------------------
module sct_back #(
  parameter int unsigned TERMS = sct_pkg::TERMS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sct_q_if.sink       q_i,
  sct_out_if.source   rsp_o
);

  localparam int unsigned VW = sct_pkg::ACC_W + 2;
  localparam logic signed [VW-1:0] PosOne = VW'(sct_pkg::ONE_Q30);
  localparam logic signed [VW-1:0] NegOne = -PosOne;

  sct_pkg::term_bus_t bus [TERMS+1];
  logic               en;

  logic                               rsp_valid_q;
  logic signed [sct_pkg::VALUE_W-1:0] rsp_value_q;

  logic signed [VW-1:0]               v_scaled, v_signed;
  logic signed [sct_pkg::VALUE_W-1:0] value_d;

  // Whole pipeline moves together; stall only while a result waits.
  assign en        = !rsp_valid_q || rsp_o.ready;
  assign q_i.ready = en;

  assign bus[0] = '{valid: q_i.valid, flip: q_i.item.flip, x2: q_i.item.x2,
                    term: sct_pkg::ONE_TERM, acc: sct_pkg::ONE_ACC};

  for (genvar g = 1; g <= TERMS; g++) begin : g_term
    sct_term #(
      .IDX (g)
    ) u_term (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .bus_i  (bus[g-1]),
      .bus_o  (bus[g])
    );
  end

  always_comb begin
    v_scaled = {bus[TERMS].acc, 2'b00};
    v_signed = bus[TERMS].flip ? -v_scaled : v_scaled;
    if (v_signed > PosOne) begin
      value_d = sct_pkg::ONE_Q30;
    end else if (v_signed < NegOne) begin
      value_d = -sct_pkg::ONE_Q30;
    end else begin
      value_d = sct_pkg::VALUE_W'(v_signed);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      rsp_valid_q <= bus[TERMS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_value_q <= value_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.value = rsp_value_q;

endmodule
